[design/grid_ray_march_unit_macros.svh]
// assertion macros shared by the ray march design
// expects clk and rst_n in the scope of the module that uses them
`ifndef GRID_RAY_MARCH_UNIT_MACROS_SVH
`define GRID_RAY_MARCH_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define GRM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid_ray_march_unit: same-cycle check failed");

// next-cycle implication, idle during reset
`define GRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid_ray_march_unit: next-cycle check failed");

`endif

[design/grm_pkg.sv]
// types, codes and constants of the grid ray march unit
// no dependencies; used by every module of the unit but grm_ram
`timescale 1ns / 1ps

package grm_pkg;

    localparam int MAP_SIDE_DEFAULT  = 32;
    localparam int MAX_STEPS_DEFAULT = 4096;

    // angle resolution is tied to the 10-bit ray_angle port
    localparam int ANGLE_STEPS = 1024;
    localparam int ANGLE_W     = 10;
    localparam int PHASE_W     = 16;
    localparam int PHASE_SHIFT = PHASE_W - $clog2(ANGLE_STEPS);

    localparam int CELL_IDX_W  = 5;
    localparam int COORD_W     = 16;
    localparam int POS_W       = 18;
    localparam int FRAC_W      = 11;
    localparam int CELL_W      = POS_W - 1 - FRAC_W;
    localparam int INC_W       = 12;
    localparam int DIM_W       = 6;
    localparam int STEP_LEN_W  = 11;
    localparam int DIST_W      = 23;
    localparam int OUTCOME_W   = 2;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 11;

    localparam logic [DIM_W-1:0]      MAP_WIDTH_RESET   = 6'd32;
    localparam logic [DIM_W-1:0]      MAP_HEIGHT_RESET  = 6'd32;
    localparam logic [STEP_LEN_W-1:0] STEP_LENGTH_RESET = 11'd102;
    localparam logic [DIST_W-1:0]     DIST_MAX          = '1;

    // sine divider: 15 quotient bits, one per cycle
    localparam int DIV_STEPS = 15;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_LEFT  = 2'd1,
        OUT_LIMIT = 2'd2
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH   = 2'd0,
        CFG_MAP_HEIGHT  = 2'd1,
        CFG_STEP_LENGTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRIG_MUL,
        ST_TRIG_LOAD,
        ST_TRIG_DIV,
        ST_TRIG_SCALE,
        ST_MARCH,
        ST_DIST,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic     clear_step;
        logic     map_write;
        logic     capture;
        logic     trig_mul;
        logic     trig_load;
        logic     div_step;
        logic     use_sin;
        logic     scale;
        logic     advance;
        logic     stop;
        outcome_t outcome;
        logic     dist_calc;
    } grm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic oob;
        logic solid;
        logic at_limit;
    } grm_status_t;

endpackage

[design/grm_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module grm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/grm_ctrl.sv]
// sequencer of the ray march unit: clear pass, map writes, trig setup, march, distance, result
// depends on grm_pkg
`timescale 1ns / 1ps

module grm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                operation,
    input  grm_pkg::grm_status_t status,
    output grm_pkg::grm_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    import grm_pkg::*;

    state_t                 state_reg, state_next;
    logic                   sin_pass_reg, sin_pass_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   div_last;
    logic                   march_stop;

    assign div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign march_stop = status.oob || status.solid || status.at_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            sin_pass_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sin_pass_reg <= sin_pass_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && (operation == OP_CAST))
                begin
                    state_next = ST_TRIG_MUL;
                end
            end
            ST_TRIG_MUL:   state_next = ST_TRIG_LOAD;
            ST_TRIG_LOAD:  state_next = ST_TRIG_DIV;
            ST_TRIG_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_TRIG_SCALE;
                end
            end
            ST_TRIG_SCALE: state_next = sin_pass_reg ? ST_MARCH : ST_TRIG_MUL;
            ST_MARCH:
            begin
                if (march_stop)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:       state_next = ST_RESULT;
            ST_RESULT:     state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // pass flag and divider count
    always_comb
    begin
        sin_pass_next = sin_pass_reg;
        div_cnt_next  = div_cnt_reg;
        if (cmd.capture)
        begin
            sin_pass_next = 1'b0;
        end
        else if (cmd.scale)
        begin
            sin_pass_next = 1'b1;
        end
        if (cmd.trig_load)
        begin
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.outcome = OUT_HIT;
        cmd.use_sin = sin_pass_reg;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:      cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (operation == OP_WRITE)
                    begin
                        cmd.map_write = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                    end
                end
            end
            ST_TRIG_MUL:   cmd.trig_mul  = 1'b1;
            ST_TRIG_LOAD:  cmd.trig_load = 1'b1;
            ST_TRIG_DIV:   cmd.div_step  = 1'b1;
            ST_TRIG_SCALE: cmd.scale     = 1'b1;
            ST_MARCH:
            begin
                // bounds first, then wall, then step limit
                priority if (status.oob)
                begin
                    cmd.stop    = 1'b1;
                    cmd.outcome = OUT_LEFT;
                end
                else if (status.solid)
                begin
                    cmd.stop    = 1'b1;
                    cmd.outcome = OUT_HIT;
                end
                else if (status.at_limit)
                begin
                    cmd.stop    = 1'b1;
                    cmd.outcome = OUT_LIMIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_DIST:       cmd.dist_calc = 1'b1;
            ST_RESULT:     done = 1'b1;
            default:       busy = 1'b1;
        endcase
    end

endmodule

[design/grm_datapath.sv]
// datapath of the ray march unit: config registers, map memory, sine divider,
// ray position, step count and distance; depends on grm_pkg and grm_ram
`timescale 1ns / 1ps

module grm_datapath #(
    parameter int MAP_SIDE  = grm_pkg::MAP_SIDE_DEFAULT,
    parameter int MAX_STEPS = grm_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  grm_pkg::grm_cmd_t                 cmd,
    output grm_pkg::grm_status_t              status,
    input  logic                              cfg_we,
    input  logic [grm_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [grm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [grm_pkg::CELL_IDX_W-1:0]    cell_x,
    input  logic [grm_pkg::CELL_IDX_W-1:0]    cell_y,
    input  logic                              cell_solid,
    input  logic [grm_pkg::COORD_W-1:0]       start_x,
    input  logic [grm_pkg::COORD_W-1:0]       start_y,
    input  logic [grm_pkg::ANGLE_W-1:0]       ray_angle,
    output logic [grm_pkg::DIST_W-1:0]        distance,
    output logic [grm_pkg::OUTCOME_W-1:0]     outcome
);

    import grm_pkg::*;

    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int PROD_W = CNT_W + STEP_LEN_W;
    localparam int MUL_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;
    localparam logic [DIM_W-1:0] SIDE_CAP  = DIM_W'((MAP_SIDE > 63) ? 63 : MAP_SIDE);
    localparam logic [8:0]       SIDE_LIM  = 9'(MAP_SIDE);
    localparam logic [32:0]      DEN_BASE  = 33'd5368709120;
    localparam logic [46:0]      ROUND_ADD = 47'd2684354560;
    localparam logic [26:0]      HALF_LSB  = 27'd8192;

    // configuration registers
    logic [DIM_W-1:0]      map_width_reg, map_width_next;
    logic [DIM_W-1:0]      map_height_reg, map_height_next;
    logic [STEP_LEN_W-1:0] step_len_reg, step_len_next;

    // clear pass
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;

    // trig setup
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [28:0]           w_reg, w_next;
    logic                  hneg_reg, hneg_next;
    logic [32:0]           den_reg, den_next;
    logic [32:0]           rem_reg, rem_next;
    logic [DIV_STEPS-1:0]  nlow_reg, nlow_next;
    logic [DIV_STEPS-1:0]  q_reg, q_next;
    logic [INC_W-1:0]      dx_reg, dx_next;
    logic [INC_W-1:0]      dy_reg, dy_next;

    // march
    logic [POS_W-1:0]      x_reg, x_next;
    logic [POS_W-1:0]      y_reg, y_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    outcome_t              outcome_reg, outcome_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;

    logic [PHASE_W-1:0]    phase_sel;
    logic [29:0]           w_full;
    logic [46:0]           n_full;
    logic [34:0]           trial;
    logic [26:0]           scaled;
    logic [INC_W-1:0]      inc_mag;
    logic [INC_W-1:0]      inc_val;
    logic [POS_W-1:0]      x_sum, y_sum, x_rd, y_rd;
    logic [DIM_W-1:0]      wd, ht;
    logic [MUL_W-1:0]      dist_prod;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr, wr_addr;
    logic                  ram_wdata, ram_rdata;
    logic                  wr_in_map;

    // ------------------------------------------------------------------
    // configuration and clear counter

    always_comb
    begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        step_len_next   = step_len_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MAP_WIDTH:   map_width_next  = cfg_wdata[DIM_W-1:0];
                CFG_MAP_HEIGHT:  map_height_next = cfg_wdata[DIM_W-1:0];
                CFG_STEP_LENGTH: step_len_next   = cfg_wdata[STEP_LEN_W-1:0];
                default:         step_len_next   = step_len_reg;
            endcase
        end
    end

    assign clr_addr_next     = cmd.clear_step ? clr_addr_reg + 1'b1 : clr_addr_reg;
    assign status.clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RESET;
            map_height_reg <= MAP_HEIGHT_RESET;
            step_len_reg   <= STEP_LENGTH_RESET;
            clr_addr_reg   <= '0;
        end
        else
        begin
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            step_len_reg   <= step_len_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // map memory

    assign wr_in_map = ({4'b0, cell_x} < SIDE_LIM) && ({4'b0, cell_y} < SIDE_LIM);
    assign wr_addr   = AW'(cell_y) * AW'(MAP_SIDE) + AW'(cell_x);

    assign ram_we    = cmd.clear_step || (cmd.map_write && wr_in_map);
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : wr_addr;
    assign ram_wdata = cmd.clear_step ? 1'b0 : cell_solid;

    // read the cell of the next position when stepping, else of the current one
    assign x_sum = x_reg + {{(POS_W - INC_W){dx_reg[INC_W-1]}}, dx_reg};
    assign y_sum = y_reg + {{(POS_W - INC_W){dy_reg[INC_W-1]}}, dy_reg};
    assign x_rd  = cmd.advance ? x_sum : x_reg;
    assign y_rd  = cmd.advance ? y_sum : y_reg;
    assign ram_raddr = AW'(y_rd[FRAC_W+CELL_W-1:FRAC_W]) * AW'(MAP_SIDE)
                     + AW'(x_rd[FRAC_W+CELL_W-1:FRAC_W]);

    grm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sine magnitude: round(2^18 * w / (5*2^30 - 4w)), w = u * (2^15 - u)

    assign phase_sel = cmd.use_sin ? phase_reg : phase_reg + 16'd16384;
    assign w_full    = 30'(phase_sel[14:0]) * (30'd32768 - 30'(phase_sel[14:0]));
    // dividend plus half the divisor, both written in terms of w
    assign n_full    = (47'(w_reg) << 18) - (47'(w_reg) << 1) + ROUND_ADD;
    assign trial     = {1'b0, rem_reg, nlow_reg[DIV_STEPS-1]} - {2'b00, den_reg};
    assign scaled    = 27'(step_len_reg) * 27'(q_reg) + HALF_LSB;
    assign inc_mag   = INC_W'(scaled[26:14]);
    assign inc_val   = hneg_reg ? (~inc_mag + 1'b1) : inc_mag;

    // ------------------------------------------------------------------
    // march bounds and limit

    assign wd = (map_width_reg > SIDE_CAP) ? SIDE_CAP : map_width_reg;
    assign ht = (map_height_reg > SIDE_CAP) ? SIDE_CAP : map_height_reg;

    assign status.oob = x_reg[POS_W-1] || y_reg[POS_W-1]
                     || (x_reg[POS_W-2:0] >= {wd, {FRAC_W{1'b0}}})
                     || (y_reg[POS_W-2:0] >= {ht, {FRAC_W{1'b0}}});
    assign status.solid    = ram_rdata;
    assign status.at_limit = (count_reg >= CNT_W'(MAX_STEPS));

    assign dist_prod = MUL_W'(count_reg) * MUL_W'(step_len_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        w_next       = w_reg;
        hneg_next    = hneg_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        nlow_next    = nlow_reg;
        q_next       = q_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        count_next   = count_reg;
        outcome_next = outcome_reg;
        dist_next    = dist_reg;

        if (cmd.capture)
        begin
            phase_next = PHASE_W'(ray_angle) << PHASE_SHIFT;
            x_next     = POS_W'(start_x);
            y_next     = POS_W'(start_y);
            count_next = '0;
        end
        if (cmd.trig_mul)
        begin
            w_next    = w_full[28:0];
            hneg_next = phase_sel[PHASE_W-1];
        end
        if (cmd.trig_load)
        begin
            den_next  = DEN_BASE - {2'b00, w_reg, 2'b00};
            rem_next  = 33'(n_full[46:DIV_STEPS]);
            nlow_next = n_full[DIV_STEPS-1:0];
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            if (!trial[34])
            begin
                rem_next = trial[32:0];
                q_next   = {q_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], nlow_reg[DIV_STEPS-1]};
                q_next   = {q_reg[DIV_STEPS-2:0], 1'b0};
            end
            nlow_next = {nlow_reg[DIV_STEPS-2:0], 1'b0};
        end
        if (cmd.scale)
        begin
            if (cmd.use_sin)
            begin
                dy_next = inc_val;
            end
            else
            begin
                dx_next = inc_val;
            end
        end
        if (cmd.advance)
        begin
            x_next     = x_sum;
            y_next     = y_sum;
            count_next = count_reg + 1'b1;
        end
        if (cmd.stop)
        begin
            outcome_next = cmd.outcome;
        end
        if (cmd.dist_calc)
        begin
            dist_next = (dist_prod > MUL_W'(DIST_MAX)) ? DIST_MAX : dist_prod[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= phase_next;
        w_reg       <= w_next;
        hneg_reg    <= hneg_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        nlow_reg    <= nlow_next;
        q_reg       <= q_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        count_reg   <= count_next;
        outcome_reg <= outcome_next;
        dist_reg    <= dist_next;
    end

    assign distance = dist_reg;
    assign outcome  = outcome_reg;

endmodule

[design/grid_ray_march_unit.sv]
// cast: after acceptance the cosine and sine setup share one divider, then the march checks
// one map cell per cycle and takes at most MAX_STEPS steps; busy drops in the cycle after
// done. a map write takes effect at its accept edge and leaves the unit idle.
// after reset the map is cleared, one cell a cycle through all MAP_SIDE*MAP_SIDE cells, with
// busy high; config registers take their reset values at once. done cannot be held off.
`timescale 1ns / 1ps

module grid_ray_march_unit #(
    parameter int MAP_SIDE  = grm_pkg::MAP_SIDE_DEFAULT,
    parameter int MAX_STEPS = grm_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [grm_pkg::CELL_IDX_W-1:0]    cell_x,
    input  logic [grm_pkg::CELL_IDX_W-1:0]    cell_y,
    input  logic                              cell_solid,
    input  logic [grm_pkg::COORD_W-1:0]       start_x,
    input  logic [grm_pkg::COORD_W-1:0]       start_y,
    input  logic [grm_pkg::ANGLE_W-1:0]       ray_angle,
    input  logic                              cfg_we,
    input  logic [grm_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [grm_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              done,
    output logic [grm_pkg::DIST_W-1:0]        distance,
    output logic [grm_pkg::OUTCOME_W-1:0]     outcome
);

    import grm_pkg::*;

`include "grid_ray_march_unit_macros.svh"

    grm_cmd_t    cmd;
    grm_status_t status;

    grm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    grm_datapath #(
        .MAP_SIDE  (MAP_SIDE),
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_solid (cell_solid),
        .start_x    (start_x),
        .start_y    (start_y),
        .ray_angle  (ray_angle),
        .distance   (distance),
        .outcome    (outcome)
    );

    // a map write transaction never occupies the unit
    `GRM_ASSERT_NEXT(a_write_stays_idle, start && !busy && (operation == OP_WRITE), !busy)
    // a cast transaction starts the trig setup, never an immediate result
    `GRM_ASSERT_NEXT(a_cast_goes_busy, start && !busy && (operation == OP_CAST), busy && !done)
    // one result per cast
    `GRM_ASSERT_NEXT(a_done_single, done, !done)
    // the ray only steps from an open in-map cell below the step limit
    `GRM_ASSERT_IMP(a_step_legal, cmd.advance, !status.at_limit && !status.oob && !status.solid)

endmodule

[tb/grid_ray_march_unit_test.sv]
// self-checking testbench for grid_ray_march_unit: map writes, ray casts and config changes
// predicts each cast result from its own ray march and checks it on the done strobe
// depends on grm_pkg and the grid_ray_march_unit design
`timescale 1ns / 1ps

module grid_ray_march_unit_test;

    import grm_pkg::*;

    localparam int MAP_SIDE       = MAP_SIDE_DEFAULT;
    localparam int MAX_STEPS      = MAX_STEPS_DEFAULT;
    localparam int CELL_ONE       = 1 << FRAC_W;
    localparam int QUIET_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 60;
    localparam int MAX_GAP        = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [DIST_W-1:0]    distance;
        logic [OUTCOME_W-1:0] outcome;
    } ray_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  operation;
    logic [CELL_IDX_W-1:0] cell_x;
    logic [CELL_IDX_W-1:0] cell_y;
    logic                  cell_solid;
    logic [COORD_W-1:0]    start_x;
    logic [COORD_W-1:0]    start_y;
    logic [ANGLE_W-1:0]    ray_angle;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  done;
    logic [DIST_W-1:0]     distance;
    logic [OUTCOME_W-1:0]  outcome;

    // predictor state: wall map and register copies
    bit          wall_map [MAP_SIDE*MAP_SIDE];
    int unsigned map_w;
    int unsigned map_h;
    int unsigned step_len;

    ray_result_t pending_rays[$];
    int          mismatch_count = 0;
    int          cast_count = 0;
    int          write_count = 0;
    int          hit_count = 0;
    int          left_count = 0;
    int          limit_count = 0;
    int          sender_idle_pct = 0;
    int          idle_cycles = 0;
    bit          start_driven_high = 1'b0;

    grid_ray_march_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_solid (cell_solid),
        .start_x    (start_x),
        .start_y    (start_y),
        .ray_angle  (ray_angle),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .distance   (distance),
        .outcome    (outcome)
    );

    always #5 clk = ~clk;

    // bhaskara sine of a 16-bit turn phase, Q1.14
    function automatic int turn_sine(input logic [PHASE_W-1:0] ph);
        longint unsigned u;
        longint unsigned w;
        longint unsigned num;
        longint unsigned den;
        int              mag;
        u   = ph[PHASE_W-2:0];
        w   = u * (64'd32768 - u);
        num = w << 18;
        den = (64'd5 << 30) - 64'd4 * w;
        mag = int'((num + den / 2) / den);
        return ph[PHASE_W-1] ? -mag : mag;
    endfunction

    // per-step increment, magnitude rounded half up
    function automatic int scale_by_step(input int trig);
        int unsigned mag;
        int unsigned prod;
        mag  = (trig < 0) ? -trig : trig;
        prod = (step_len * mag + 32'd8192) >> 14;
        return (trig < 0) ? -int'(prod) : int'(prod);
    endfunction

    function automatic ray_result_t trace_ray(input logic [COORD_W-1:0] sx,
                                              input logic [COORD_W-1:0] sy,
                                              input logic [ANGLE_W-1:0] ang);
        int unsigned     wd;
        int unsigned     ht;
        int unsigned     nsteps;
        int              x;
        int              y;
        int              dx;
        int              dy;
        int              xlim;
        int              ylim;
        bit              stopped;
        logic [PHASE_W-1:0] ph;
        longint unsigned d;
        ray_result_t     r;
        wd   = (map_w > MAP_SIDE) ? MAP_SIDE : map_w;
        ht   = (map_h > MAP_SIDE) ? MAP_SIDE : map_h;
        xlim = wd * CELL_ONE;
        ylim = ht * CELL_ONE;
        ph   = {ang, {PHASE_SHIFT{1'b0}}};
        dx   = scale_by_step(turn_sine(ph + 16'd16384));
        dy   = scale_by_step(turn_sine(ph));
        x    = sx;
        y    = sy;
        nsteps  = 0;
        stopped = 1'b0;
        r.outcome = OUT_LEFT;
        while (!stopped)
        begin
            if (x < 0 || y < 0 || x >= xlim || y >= ylim)
            begin
                r.outcome = OUT_LEFT;
                stopped = 1'b1;
            end
            else if (wall_map[(y >> FRAC_W) * MAP_SIDE + (x >> FRAC_W)])
            begin
                r.outcome = OUT_HIT;
                stopped = 1'b1;
            end
            else if (nsteps >= MAX_STEPS)
            begin
                r.outcome = OUT_LIMIT;
                stopped = 1'b1;
            end
            else
            begin
                x = x + dx;
                y = y + dy;
                nsteps++;
            end
        end
        d = longint'(nsteps) * longint'(step_len);
        if (d > DIST_MAX)
            d = DIST_MAX;
        r.distance = d[DIST_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic release_start();
        if (start_driven_high)
        begin
            start <= 1'b0;
            start_driven_high = 1'b0;
        end
    endtask

    // one transaction; the predictor is updated at the accepting edge
    task automatic send_item(input op_t op, input logic [CELL_IDX_W-1:0] cx,
                             input logic [CELL_IDX_W-1:0] cy, input logic solid,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [ANGLE_W-1:0] ang);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99, 0) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            release_start();
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        cell_x     <= cx;
        cell_y     <= cy;
        cell_solid <= solid;
        start_x    <= sx;
        start_y    <= sy;
        ray_angle  <= ang;
        start_driven_high = 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (op == OP_WRITE)
        begin
            wall_map[cy * MAP_SIDE + cx] = solid;
            write_count++;
        end
        else
        begin
            pending_rays.push_back(trace_ray(sx, sy, ang));
            cast_count++;
        end
    endtask

    task automatic write_cell(input logic [CELL_IDX_W-1:0] cx,
                              input logic [CELL_IDX_W-1:0] cy, input logic solid);
        send_item(OP_WRITE, cx, cy, solid, COORD_W'($urandom), COORD_W'($urandom),
                  ANGLE_W'($urandom));
    endtask

    task automatic cast_ray(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                            input logic [ANGLE_W-1:0] ang);
        send_item(OP_CAST, CELL_IDX_W'($urandom), CELL_IDX_W'($urandom), 1'($urandom),
                  sx, sy, ang);
    endtask

    task automatic wait_for_quiet();
        release_start();
        do
            @(posedge clk);
        while (pending_rays.size() != 0 || busy !== 1'b0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_MAP_WIDTH:   map_w = val[DIM_W-1:0];
            CFG_MAP_HEIGHT:  map_h = val[DIM_W-1:0];
            CFG_STEP_LENGTH: step_len = val;
            default: ;
        endcase
    endtask

    // upper data bits of the dimension writes carry noise the unit must drop
    task automatic load_config(input int unsigned w_val, input int unsigned h_val,
                               input int unsigned len_val);
        wait_for_quiet();
        write_reg(CFG_MAP_WIDTH, {5'($urandom), 6'(w_val)});
        write_reg(CFG_MAP_HEIGHT, {5'($urandom), 6'(h_val)});
        write_reg(CFG_STEP_LENGTH, 11'(len_val));
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        ray_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_rays.size() == 0)
                report_mismatch("result with no cast waiting", outcome, 0);
            else
            begin
                want = pending_rays.pop_front();
                if (distance !== want.distance)
                    report_mismatch("distance", distance, want.distance);
                if (outcome !== want.outcome)
                    report_mismatch("outcome", outcome, want.outcome);
                case (want.outcome)
                    OUT_HIT:  hit_count++;
                    OUT_LEFT: left_count++;
                    default:  limit_count++;
                endcase
            end
        end
    end

    // cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("grid_ray_march_unit: mismatch");
                $finish;
            end
        end
    end

    // register values straight out of reset, empty map
    task automatic test_reset_values();
        cast_ray(16'(16 * CELL_ONE + 1024), 16'(16 * CELL_ONE + 1024), 10'd0);
        cast_ray(16'(16 * CELL_ONE + 1024), 16'(16 * CELL_ONE + 1024), 10'd256);
        cast_ray(16'd0, 16'd0, 10'd512);
        cast_ray(16'hFFFF, 16'hFFFF, 10'd128);
    endtask

    task automatic test_wall_hits();
        load_config(32, 32, 1024);
        write_cell(5'd20, 5'd16, 1'b1);
        cast_ray(16'(16 * CELL_ONE + 1024), 16'(16 * CELL_ONE + 1024), 10'd0);
        write_cell(5'd0, 5'd0, 1'b1);
        write_cell(5'd31, 5'd31, 1'b1);
        // starting inside a wall stops at once
        cast_ray(16'd100, 16'd100, 10'd700);
        cast_ray(16'(31 * CELL_ONE), 16'(30 * CELL_ONE), 10'd256);
        write_cell(5'd20, 5'd16, 1'b0);
        cast_ray(16'(16 * CELL_ONE + 1024), 16'(16 * CELL_ONE + 1024), 10'd0);
        write_cell(5'd0, 5'd0, 1'b0);
        write_cell(5'd31, 5'd31, 1'b0);
    endtask

    // a coordinate equal to the width or height lies outside
    task automatic test_map_edges();
        load_config(16, 8, 2047);
        cast_ray(16'(16 * CELL_ONE), 16'd0, 10'd512);
        cast_ray(16'(16 * CELL_ONE - 1), 16'd0, 10'd0);
        cast_ray(16'd0, 16'(8 * CELL_ONE), 10'd768);
        cast_ray(16'd0, 16'(8 * CELL_ONE - 1), 10'd1023);
    endtask

    task automatic test_config_extremes();
        // zero width: everything starts outside
        load_config(0, 32, 102);
        cast_ray(16'd5000, 16'd5000, 10'd0);
        // oversized dimensions saturate, smallest step runs into the step limit
        load_config(63, 63, 1);
        cast_ray(16'd0, 16'd0, 10'd0);
        // zero step length stands still until the limit
        load_config(32, 1, 0);
        cast_ray(16'd3000, 16'd1000, 10'd300);
        load_config(1, 1, 2047);
        cast_ray(16'd1000, 16'd1000, 10'd128);
        cast_ray(16'd1000, 16'd2047, 10'd256);
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned len;
        for (phase = 0; phase < 4; phase++)
        begin
            len = ($urandom_range(9, 0) < 7) ? $urandom_range(2047, 64)
                                              : $urandom_range(2047, 1);
            load_config($urandom_range(1, 0) ? $urandom_range(32, 1) : $urandom_range(63, 1),
                        $urandom_range(1, 0) ? $urandom_range(32, 1) : $urandom_range(63, 1),
                        len);
            sender_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 26 : 0;
            eff_w = (map_w > MAP_SIDE) ? MAP_SIDE : map_w;
            eff_h = (map_h > MAP_SIDE) ? MAP_SIDE : map_h;
            for (n = 0; n < 29; n++)
            begin
                if ($urandom_range(9, 0) < 3)
                begin
                    // walls mostly inside the area in use
                    if ($urandom_range(9, 0) < 7)
                        write_cell(CELL_IDX_W'($urandom_range(eff_w - 1, 0)),
                                   CELL_IDX_W'($urandom_range(eff_h - 1, 0)),
                                   1'($urandom_range(1, 0)));
                    else
                        write_cell(CELL_IDX_W'($urandom), CELL_IDX_W'($urandom),
                                   1'($urandom));
                end
                else
                begin
                    if ($urandom_range(9, 0) < 8)
                        cast_ray(COORD_W'($urandom_range(eff_w * CELL_ONE - 1, 0)),
                                 COORD_W'($urandom_range(eff_h * CELL_ONE - 1, 0)),
                                 ANGLE_W'($urandom));
                    else
                        cast_ray(COORD_W'($urandom), COORD_W'($urandom), ANGLE_W'($urandom));
                end
            end
        end
        sender_idle_pct = 0;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        operation  <= OP_WRITE;
        cell_x     <= '0;
        cell_y     <= '0;
        cell_solid <= 1'b0;
        start_x    <= '0;
        start_y    <= '0;
        ray_angle  <= '0;
        cfg_we     <= 1'b0;
        cfg_addr   <= CFG_MAP_WIDTH;
        cfg_wdata  <= '0;
        foreach (wall_map[i])
            wall_map[i] = 1'b0;
        map_w    = MAP_WIDTH_RESET;
        map_h    = MAP_HEIGHT_RESET;
        step_len = STEP_LENGTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_wall_hits();
        test_map_edges();
        test_config_extremes();
        test_random_traffic();

        wait_for_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d ray casts and %0d map writes over several register settings",
                 cast_count, write_count);
        $display("checked endings: %0d wall hits, %0d exits from the map, %0d step limits",
                 hit_count, left_count, limit_count);
        if (mismatch_count == 0)
            $display("grid_ray_march_unit: match");
        else
            $display("grid_ray_march_unit: mismatch");
        $finish;
    end

endmodule
